[rtl/ssmmg_pkg.sv]
package ssmmg_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int CAP_W    = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int STAT_W   = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic gap;
    } t_cell_ctl;

endpackage

[rtl/ssmmg_if.sv]
interface ssmmg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssmmg_pkg::VAL_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface ssmmg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [ssmmg_pkg::STAT_W-1:0]         status;
    logic [ssmmg_pkg::CAP_W-1:0]          count;
    logic                                 span_valid;
    logic [ssmmg_pkg::VAL_W-1:0]          shortest_span;
    logic [ssmmg_pkg::VAL_W-1:0]          longest_span;

    modport source (output valid, output status, output count, output span_valid,
                    output shortest_span, output longest_span, input ready);
    modport sink   (input valid, input status, input count, input span_valid,
                    input shortest_span, input longest_span, output ready);
endinterface

[rtl/ssmmg_cell.sv]
module ssmmg_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssmmg_pkg::t_cell_ctl              i_ctl,
    input  logic [ssmmg_pkg::VAL_W-1:0]       i_key,
    input  logic                              i_head,
    input  logic [ssmmg_pkg::VAL_W-1:0]       i_left_val,
    input  logic                              i_left_occ,
    input  logic                              i_left_shift,
    input  logic [ssmmg_pkg::VAL_W-1:0]       i_right_val,
    input  logic                              i_right_occ,
    output logic [ssmmg_pkg::VAL_W-1:0]       o_val,
    output logic                              o_occ,
    output logic                              o_shift,
    output logic                              o_eq,
    output logic [ssmmg_pkg::VAL_W-1:0]       o_cand,
    output logic [ssmmg_pkg::VAL_W-1:0]       o_tail
);

    logic [ssmmg_pkg::VAL_W-1:0] r_val;
    logic                        r_occ;
    logic                        r_new;
    logic                        r_gt;
    logic                        r_eq;
    logic [ssmmg_pkg::VAL_W-1:0] r_cand;
    logic [ssmmg_pkg::VAL_W-1:0] r_tail;

    logic                        w_place;
    logic [ssmmg_pkg::VAL_W-1:0] w_lgap;
    logic [ssmmg_pkg::VAL_W-1:0] w_rgap;

    assign w_place = r_gt && !i_left_shift && (i_left_occ || i_head);
    assign w_lgap  = i_left_occ  ? (r_val - i_left_val) : '1;
    assign w_rgap  = i_right_occ ? (i_right_val - r_val) : '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_new <= 1'b0;
            r_gt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_gt <= !r_occ || ($signed(r_val) > $signed(i_key));
                r_eq <= r_occ && (r_val == i_key);
            end
            if (i_ctl.ins) begin
                if (i_left_shift) begin
                    r_val <= i_left_val;
                    r_occ <= 1'b1;
                    r_new <= 1'b0;
                end else if (w_place) begin
                    r_val <= i_key;
                    r_occ <= 1'b1;
                    r_new <= 1'b1;
                end else begin
                    r_new <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.gap) begin
            r_cand <= r_new ? ((w_lgap < w_rgap) ? w_lgap : w_rgap) : '0;
            r_tail <= (r_occ && !i_right_occ) ? r_val : '0;
        end
    end

    assign o_val   = r_val;
    assign o_occ   = r_occ;
    assign o_shift = r_occ && r_gt;
    assign o_eq    = r_eq;
    assign o_cand  = r_cand;
    assign o_tail  = r_tail;

endmodule

[rtl/sorted_set_min_max_gap.sv]
// Channel   Direction  Payload
// i_in      in         value (signed 32)
// o_out     out        status, count, span_valid, shortest_span, longest_span
// i_cfg_*   in         capacity (7 bits), written when i_cfg_we is high
//
// Each request goes through accept, compare in every cell, shift the row of
// cells, local gap in the inserted cell, then one reduction over the row that
// loads the output register. Requests are handled one at a time.
// Reset is synchronous and empties the row at once. The next request is
// accepted while a result waits; the reduction stalls while the output is full.
module sorted_set_min_max_gap (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ssmmg_in_if.sink                           i_in,
    ssmmg_out_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [ssmmg_pkg::CAP_W-1:0]        i_cfg_data
);

    localparam int N = ssmmg_pkg::CAPACITY;
    localparam int W = ssmmg_pkg::VAL_W;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CMP   = 5'b00010,
        PH_SHIFT = 5'b00100,
        PH_GAP   = 5'b01000,
        PH_RED   = 5'b10000
    } t_phase;

    t_phase                            r_phase;
    t_phase                            n_phase;
    logic [ssmmg_pkg::CAP_W-1:0]       r_cap;
    logic [W-1:0]                      r_key;
    logic [ssmmg_pkg::CNT_W-1:0]       r_held;
    logic [W-1:0]                      r_best;
    logic                              r_ins;
    ssmmg_pkg::t_status                r_status;

    logic                              r_out_valid;
    ssmmg_pkg::t_status                r_out_status;
    logic [ssmmg_pkg::CAP_W-1:0]       r_out_count;
    logic                              r_out_span_valid;
    logic [W-1:0]                      r_out_shortest;
    logic [W-1:0]                      r_out_longest;

    ssmmg_pkg::t_cell_ctl              w_ctl;
    logic [W-1:0]                      w_val   [N];
    logic [N-1:0]                      w_occ;
    logic [N-1:0]                      w_shift;
    logic [N-1:0]                      w_eq;
    logic [W-1:0]                      w_cand  [N];
    logic [W-1:0]                      w_tail  [N];

    logic                              w_full;
    logic                              w_dup;
    logic                              w_do_ins;
    logic [W-1:0]                      w_cand_or;
    logic [W-1:0]                      w_tail_or;
    logic [W-1:0]                      w_best_next;
    logic                              w_span_valid;
    logic                              w_out_free;

    assign w_full = (ssmmg_pkg::CMP_W'(r_held) >= ssmmg_pkg::CMP_W'(r_cap))
                 || (ssmmg_pkg::CMP_W'(r_held) >= ssmmg_pkg::CMP_W'(N));
    assign w_dup    = |w_eq;
    assign w_do_ins = (r_phase == PH_SHIFT) && !w_full && !w_dup;

    assign w_ctl.cmp = (r_phase == PH_CMP);
    assign w_ctl.ins = w_do_ins;
    assign w_ctl.gap = (r_phase == PH_GAP);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_first
                ssmmg_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl),
                    .i_key        (r_key),
                    .i_head       (1'b1),
                    .i_left_val   ('0),
                    .i_left_occ   (1'b0),
                    .i_left_shift (1'b0),
                    .i_right_val  (w_val[g+1]),
                    .i_right_occ  (w_occ[g+1]),
                    .o_val        (w_val[g]),
                    .o_occ        (w_occ[g]),
                    .o_shift      (w_shift[g]),
                    .o_eq         (w_eq[g]),
                    .o_cand       (w_cand[g]),
                    .o_tail       (w_tail[g])
                );
            end else if (g == N - 1) begin : g_last
                ssmmg_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl),
                    .i_key        (r_key),
                    .i_head       (1'b0),
                    .i_left_val   (w_val[g-1]),
                    .i_left_occ   (w_occ[g-1]),
                    .i_left_shift (w_shift[g-1]),
                    .i_right_val  ('0),
                    .i_right_occ  (1'b0),
                    .o_val        (w_val[g]),
                    .o_occ        (w_occ[g]),
                    .o_shift      (w_shift[g]),
                    .o_eq         (w_eq[g]),
                    .o_cand       (w_cand[g]),
                    .o_tail       (w_tail[g])
                );
            end else begin : g_mid
                ssmmg_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl),
                    .i_key        (r_key),
                    .i_head       (1'b0),
                    .i_left_val   (w_val[g-1]),
                    .i_left_occ   (w_occ[g-1]),
                    .i_left_shift (w_shift[g-1]),
                    .i_right_val  (w_val[g+1]),
                    .i_right_occ  (w_occ[g+1]),
                    .o_val        (w_val[g]),
                    .o_occ        (w_occ[g]),
                    .o_shift      (w_shift[g]),
                    .o_eq         (w_eq[g]),
                    .o_cand       (w_cand[g]),
                    .o_tail       (w_tail[g])
                );
            end
        end
    endgenerate

    // Only the most recently inserted cell and the last occupied cell drive non-zero values.
    always_comb begin
        w_cand_or = '0;
        w_tail_or = '0;
        for (int i = 0; i < N; i++) begin
            w_cand_or = w_cand_or | w_cand[i];
            w_tail_or = w_tail_or | w_tail[i];
        end
    end

    assign w_best_next  = (r_ins && (w_cand_or < r_best)) ? w_cand_or : r_best;
    assign w_span_valid = (r_held >= ssmmg_pkg::CNT_W'(2));
    assign w_out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE:  begin
                if (i_in.valid) begin
                    n_phase = PH_CMP;
                end
            end
            PH_CMP:   n_phase = PH_SHIFT;
            PH_SHIFT: n_phase = PH_GAP;
            PH_GAP:   n_phase = PH_RED;
            PH_RED:   begin
                if (w_out_free) begin
                    n_phase = PH_IDLE;
                end
            end
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cap       <= ssmmg_pkg::CAP_W'(N);
            r_held      <= '0;
            r_best      <= '1;
            r_ins       <= 1'b0;
            r_status    <= ssmmg_pkg::ST_INSERTED;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (r_phase == PH_SHIFT) begin
                r_ins <= w_do_ins;
                if (w_full) begin
                    r_status <= ssmmg_pkg::ST_FULL;
                end else if (w_dup) begin
                    r_status <= ssmmg_pkg::ST_DUPLICATE;
                end else begin
                    r_status <= ssmmg_pkg::ST_INSERTED;
                    r_held   <= r_held + ssmmg_pkg::CNT_W'(1);
                end
            end
            if ((r_phase == PH_RED) && w_out_free) begin
                r_best      <= w_best_next;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key <= i_in.value;
        end
        if ((r_phase == PH_RED) && w_out_free) begin
            r_out_status     <= r_status;
            r_out_count      <= ssmmg_pkg::CAP_W'(ssmmg_pkg::CMP_W'(r_held));
            r_out_span_valid <= w_span_valid;
            r_out_shortest   <= w_span_valid ? w_best_next : '0;
            r_out_longest    <= w_span_valid ? (w_tail_or - w_val[0]) : '0;
        end
    end

    assign i_in.ready          = (r_phase == PH_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.count         = r_out_count;
    assign o_out.span_valid    = r_out_span_valid;
    assign o_out.shortest_span = r_out_shortest;
    assign o_out.longest_span  = r_out_longest;

endmodule

[dv/sorted_set_min_max_gap_tb.sv]
module sorted_set_min_max_gap_tb;

    localparam int VAL_W           = ssmmg_pkg::VAL_W;
    localparam int CAP_W           = ssmmg_pkg::CAP_W;
    localparam int CAPACITY        = ssmmg_pkg::CAPACITY;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 12;

    typedef struct packed {
        ssmmg_pkg::t_status status;
        logic [CAP_W-1:0]   count;
        logic               span_valid;
        logic [VAL_W-1:0]   shortest;
        logic [VAL_W-1:0]   longest;
    } t_span_result;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;

    ssmmg_in_if  in_ch ();
    ssmmg_out_if out_ch ();

    sorted_set_min_max_gap u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    logic signed [VAL_W-1:0] held_vals [CAPACITY];
    int                      held_n;
    logic [VAL_W-1:0]        min_gap;
    logic [CAP_W-1:0]        capacity_cfg;
    t_span_result            expected_q [$];
    int                      error_count;
    int                      idle_cycles;
    int                      stall_left;
    bit                      calm;

    always #5 clk = ~clk;

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        held_n       = 0;
        min_gap      = '1;
        capacity_cfg = 7'd64;
        error_count  = 0;
        idle_cycles  = 0;
        stall_left   = 0;
        calm         = 1'b0;
    end

    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 93) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // Mirrors one insertion into the sorted store and queues the result it gives.
    task automatic predict_insert(input logic signed [VAL_W-1:0] v);
        int           limit;
        int           pos;
        logic [VAL_W-1:0] g;
        t_span_result r;
        limit = (capacity_cfg < CAPACITY) ? int'(capacity_cfg) : CAPACITY;
        pos   = 0;
        if (held_n >= limit) begin
            r.status = ssmmg_pkg::ST_FULL;
        end else begin
            while (pos < held_n && held_vals[pos] < v) pos++;
            if (pos < held_n && held_vals[pos] == v) begin
                r.status = ssmmg_pkg::ST_DUPLICATE;
            end else begin
                for (int i = held_n; i > pos; i--) held_vals[i] = held_vals[i-1];
                held_vals[pos] = v;
                held_n++;
                if (pos > 0) begin
                    g = v - held_vals[pos-1];
                    if (g < min_gap) min_gap = g;
                end
                if (pos + 1 < held_n) begin
                    g = held_vals[pos+1] - v;
                    if (g < min_gap) min_gap = g;
                end
                r.status = ssmmg_pkg::ST_INSERTED;
            end
        end
        r.count      = CAP_W'(held_n);
        r.span_valid = (held_n >= 2);
        r.shortest   = r.span_valid ? min_gap : '0;
        r.longest    = r.span_valid ? VAL_W'(held_vals[held_n-1] - held_vals[0]) : '0;
        expected_q.push_back(r);
    endtask

    task automatic send_value(input logic signed [VAL_W-1:0] v);
        int idle;
        idle = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (idle > 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_insert(v);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(negedge clk);
        cfg_we   <= 1'b0;
        capacity_cfg = c;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned             mode;
        logic signed [VAL_W-1:0] v;
        mode = $urandom_range(0, 9);
        v    = $urandom;
        case (mode)
            4, 5: v = int'($urandom_range(0, 400)) - 200;
            6: if (held_n > 0) v = held_vals[$urandom_range(0, held_n - 1)];
            7: begin
                if ($urandom_range(0, 1) != 0) begin
                    v = 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
                end else begin
                    v = 32'sh8000_0000 + int'($urandom_range(0, 3));
                end
            end
            8: begin
                if (held_n > 0) begin
                    v = held_vals[$urandom_range(0, held_n - 1)] + int'($urandom_range(0, 4)) - 2;
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed_values();
        send_value(32'sd5);
        send_value(32'sd5);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sd0);
        send_value(-32'sd1);
        send_value(32'sd6);
        send_value(32'sh8000_0000);
    endtask

    task automatic test_capacity_edges();
        set_capacity(7'd0);
        send_value(32'sd0);
        send_value(32'sd42);
        set_capacity(7'd8);
        send_value(32'sd100);
        send_value(-32'sd100);
        send_value(32'sd7);
        send_value(32'sd6);
        set_capacity(7'd3);
        send_value(32'sd1000);
        send_value(32'sd100);
        set_capacity(7'd127);
        send_value(32'sd9);
    endtask

    task automatic test_random_growth();
        int caps [7] = '{16, 24, 32, 40, 48, 56, 127};
        foreach (caps[p]) begin
            set_capacity(CAP_W'(caps[p]));
            calm = (p == 3);
            repeat (85) send_value(pick_value());
        end
        calm = 1'b0;
    endtask

    task automatic test_full_refusal();
        int caps [6] = '{100, 64, 65, 3, 0, 127};
        foreach (caps[p]) begin
            set_capacity(CAP_W'(caps[p]));
            repeat (35) send_value(pick_value());
        end
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (calm || $urandom_range(0, 4) != 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= 1'b0;
            stall_left = gap_len() - 1;
        end
    end

    task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        t_span_result e;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request pending, status %0d count %0d",
                         $time, out_ch.status, out_ch.count);
                error_count++;
            end else begin
                e = expected_q.pop_front();
                check_field("status", VAL_W'(e.status), VAL_W'(out_ch.status));
                check_field("count", VAL_W'(e.count), VAL_W'(out_ch.count));
                check_field("span_valid", VAL_W'(e.span_valid), VAL_W'(out_ch.span_valid));
                check_field("shortest_span", e.shortest, out_ch.shortest_span);
                check_field("longest_span", e.longest, out_ch.longest_span);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("sorted_set_min_max_gap regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_values();
        test_capacity_edges();
        test_random_growth();
        test_full_refusal();
        drain();
        if (error_count == 0) begin
            $display("sorted_set_min_max_gap regression: pass");
        end else begin
            $display("sorted_set_min_max_gap regression: fail");
        end
        $finish;
    end

endmodule
